@@ design/ipv4c_pkg.sv @@
`timescale 1ns / 1ps

package ipv4c_pkg;

  // Bytes past this count are dropped and not counted.
  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [3:0]  IHL_MASK       = 4'hF;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [15:0] FLAG_MF        = 16'h2000;
  localparam logic [15:0] OFFSET_MASK    = 16'h1FFF;
  localparam logic [7:0]  LOOPBACK_NET   = 8'd127;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef enum logic [3:0] {
    VERDICT_ICMP       = 4'd0,
    VERDICT_UDP        = 4'd1,
    VERDICT_TCP        = 4'd2,
    VERDICT_IGNORED    = 4'd3,
    VERDICT_BAD_LENGTH = 4'd4,
    VERDICT_BAD_SUM    = 4'd5,
    VERDICT_FRAGMENT   = 4'd6,
    VERDICT_NOT_OURS   = 4'd7,
    VERDICT_UNHANDLED  = 4'd8
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ipv4c_in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
    logic [7:0]  time_to_live;
    logic [31:0] drop_count;
  } ipv4c_res_t;

  // Everything the front part gathered about one packet.
  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       version_ihl;
    logic [15:0]      total_length;
    logic [15:0]      flags_offset;
    logic [7:0]       ttl_value;
    logic [7:0]       protocol_value;
    logic [31:0]      src_value;
    logic [31:0]      dst_value;
    logic [15:0]      sum_value;
  } ipv4c_rec_t;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] subnet_mask;
    logic        is_configured;
  } ipv4c_cfg_t;

endpackage

@@ design/ipv4c_front.sv @@
`timescale 1ns / 1ps

module ipv4c_front import ipv4c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  ipv4c_in_t  in_data_i,
  output logic       rec_push_o,
  output ipv4c_rec_t rec_o
);

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [7:0]       vihl_q, vihl_d;
  logic [15:0]      tlen_q, tlen_d;
  logic [15:0]      flags_q, flags_d;
  logic [7:0]       ttl_q, ttl_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_q, src_d;
  logic [31:0]      dst_q, dst_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       hold_q, hold_d;

  logic       take;
  logic [7:0] b;
  logic [5:0] hdr_len;
  logic       in_hdr;
  logic [16:0] sum_wide;

  assign b    = in_data_i.data_byte;
  assign take = accept_i && (idx_q < CNT_W'(MAX_PACKET_BYTES));

  always_comb begin
    idx_d   = idx_q;
    vihl_d  = vihl_q;
    tlen_d  = tlen_q;
    flags_d = flags_q;
    ttl_d   = ttl_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    sum_d   = sum_q;
    hold_d  = hold_q;

    if (take && idx_q == CNT_W'(0)) begin
      vihl_d = b;
    end
    // The header length in force for this byte includes byte 0 itself.
    hdr_len  = {vihl_d[3:0] & IHL_MASK, 2'b00};
    in_hdr   = idx_q < CNT_W'(hdr_len);
    sum_wide = {1'b0, sum_q} + {1'b0, hold_q, b};

    if (take) begin
      idx_d = idx_q + CNT_W'(1);
      if (idx_q == CNT_W'(2) || idx_q == CNT_W'(3)) begin
        tlen_d = {tlen_q[7:0], b};
      end
      if (idx_q == CNT_W'(6) || idx_q == CNT_W'(7)) begin
        flags_d = {flags_q[7:0], b};
      end
      if (idx_q == CNT_W'(8)) begin
        ttl_d = b;
      end
      if (idx_q == CNT_W'(9)) begin
        proto_d = b;
      end
      if (idx_q >= CNT_W'(12) && idx_q < CNT_W'(16)) begin
        src_d = {src_q[23:0], b};
      end
      if (idx_q >= CNT_W'(16) && idx_q < CNT_W'(20)) begin
        dst_d = {dst_q[23:0], b};
      end
      if (in_hdr) begin
        if (!idx_q[0]) begin
          hold_d = b;
        end else begin
          sum_d = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end
      end
    end
  end

  assign rec_push_o = accept_i && in_data_i.last_byte;

  always_comb begin
    rec_o.byte_count     = idx_d;
    rec_o.version_ihl    = vihl_d;
    rec_o.total_length   = tlen_d;
    rec_o.flags_offset   = flags_d;
    rec_o.ttl_value      = ttl_d;
    rec_o.protocol_value = proto_d;
    rec_o.src_value      = src_d;
    rec_o.dst_value      = dst_d;
    rec_o.sum_value      = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      vihl_q  <= '0;
      tlen_q  <= '0;
      flags_q <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
    end else if (rec_push_o) begin
      idx_q   <= '0;
      vihl_q  <= '0;
      tlen_q  <= '0;
      flags_q <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
    end else begin
      idx_q   <= idx_d;
      vihl_q  <= vihl_d;
      tlen_q  <= tlen_d;
      flags_q <= flags_d;
      ttl_q   <= ttl_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
    end
  end

endmodule

@@ design/ipv4c_rec_queue.sv @@
`timescale 1ns / 1ps

module ipv4c_rec_queue import ipv4c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ipv4c_rec_t rec_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output ipv4c_rec_t rec_o
);

  ipv4c_rec_t  mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rec_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule

@@ design/ipv4c_back.sv @@
`timescale 1ns / 1ps

module ipv4c_back import ipv4c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ipv4c_cfg_t cfg_i,
  input  logic       rec_valid_i,
  input  ipv4c_rec_t rec_i,
  output logic       rec_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output ipv4c_res_t res_o
);

  ipv4c_res_t  oq_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic [31:0] drop_q, drop_d;

  logic        take, do_pop;
  logic [5:0]  hdr_len;
  logic [16:0] cnt_ext, tlen_ext, hdr_ext;
  logic [31:0] dst, bcast;
  logic        ours, deliver, is_drop;
  verdict_e    verdict;
  ipv4c_res_t  res_new;

  assign take      = rec_valid_i && (cnt_q != 2'd2);
  assign rec_pop_o = take;
  assign empty_o   = cnt_q == 2'd0;
  assign do_pop    = pop_i && !empty_o;
  assign res_o     = oq_q[rptr_q];

  assign hdr_len  = {rec_i.version_ihl[3:0] & IHL_MASK, 2'b00};
  assign cnt_ext  = 17'(rec_i.byte_count);
  assign tlen_ext = {1'b0, rec_i.total_length};
  assign hdr_ext  = {11'd0, hdr_len};
  assign dst      = rec_i.dst_value;
  assign bcast    = (cfg_i.local_address & cfg_i.subnet_mask) | ~cfg_i.subnet_mask;

  assign ours = (dst == 32'hFFFF_FFFF) || !cfg_i.is_configured ||
                (dst == cfg_i.local_address) || (dst[31:24] == LOOPBACK_NET) ||
                ((cfg_i.subnet_mask != 32'd0) && (dst == bcast));

  always_comb begin
    if (cnt_ext < 17'd20 || rec_i.version_ihl[7:4] != IP_VERSION_4) begin
      verdict = VERDICT_IGNORED;
    end else if (hdr_len < MIN_HDR_BYTES || tlen_ext < hdr_ext || tlen_ext > cnt_ext) begin
      verdict = VERDICT_BAD_LENGTH;
    end else if (rec_i.sum_value != SUM_GOOD) begin
      verdict = VERDICT_BAD_SUM;
    end else if ((rec_i.flags_offset & FLAG_MF) != 16'd0 ||
                 (rec_i.flags_offset & OFFSET_MASK) != 16'd0) begin
      verdict = VERDICT_FRAGMENT;
    end else if (!ours) begin
      verdict = VERDICT_NOT_OURS;
    end else if (rec_i.protocol_value == PROTO_ICMP) begin
      verdict = VERDICT_ICMP;
    end else if (rec_i.protocol_value == PROTO_UDP) begin
      verdict = VERDICT_UDP;
    end else if (rec_i.protocol_value == PROTO_TCP && cfg_i.is_configured) begin
      verdict = VERDICT_TCP;
    end else begin
      verdict = VERDICT_UNHANDLED;
    end
  end

  assign deliver = (verdict == VERDICT_ICMP) || (verdict == VERDICT_UDP) ||
                   (verdict == VERDICT_TCP);
  assign is_drop = (verdict == VERDICT_BAD_LENGTH) || (verdict == VERDICT_BAD_SUM) ||
                   (verdict == VERDICT_FRAGMENT);

  always_comb begin
    drop_d = drop_q;
    if (take && is_drop && drop_q != 32'hFFFF_FFFF) begin
      drop_d = drop_q + 32'd1;
    end
  end

  always_comb begin
    res_new.verdict        = verdict;
    res_new.source_address = (cnt_ext >= 17'd16) ? rec_i.src_value : 32'd0;
    res_new.dest_address   = (cnt_ext >= 17'd20) ? rec_i.dst_value : 32'd0;
    res_new.header_bytes   = deliver ? hdr_len : 6'd0;
    res_new.payload_length = deliver ? (rec_i.total_length - {10'd0, hdr_len}) : 16'd0;
    res_new.time_to_live   = rec_i.ttl_value;
    res_new.drop_count     = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
      drop_q <= 32'd0;
    end else begin
      drop_q <= drop_d;
      if (take) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (take && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !take) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      oq_q[wptr_q] <= res_new;
    end
  end

endmodule

@@ design/ipv4_receive_header_checker_top.sv @@
`timescale 1ns / 1ps

// IPv4 receive header checker.
// Input channel: packet bytes arrive on in_data_i, header first, with last_byte
// set on the final byte; a word is taken on a rising edge with push high and full
// low. One byte is taken every cycle while full is low.
// Result channel: one verdict word per packet, queue style; the oldest word sits
// on res_o while empty is low and is taken with pop high.
// Flow: a packet's summary is registered in the summary queue when its last byte
// is taken, then its verdict in the result queue. A packet can finish every cycle;
// the judging stage handles one packet per cycle while the result queue has room.
// Configuration: local address, subnet mask and the configured flag sit behind an
// APB port at byte addresses 0, 4 and 8; write them only while no packet is open
// and no verdict is outstanding.
// Reset clears the configuration, the drop counter and both queues.
// When the receiver stalls, up to two verdicts wait in the result queue and two
// packet summaries behind them; once those fill, full rises and bytes are held
// off until pop frees a place.
module ipv4_receive_header_checker_top import ipv4c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  ipv4c_in_t   in_data_i,
  output logic        empty,
  input  logic        pop,
  output ipv4c_res_t  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SUBNET_MASK   = 2'd1;
  localparam logic [1:0] REG_IS_CONFIGURED = 2'd2;

  ipv4c_cfg_t cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic       accept;
  logic       rec_push, rec_valid, rec_pop;
  ipv4c_rec_t rec_in, rec_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LOCAL_ADDRESS: cfg_q.local_address <= pwdata;
        REG_SUBNET_MASK:   cfg_q.subnet_mask   <= pwdata;
        REG_IS_CONFIGURED: cfg_q.is_configured <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOCAL_ADDRESS: prdata = cfg_q.local_address;
      REG_SUBNET_MASK:   prdata = cfg_q.subnet_mask;
      REG_IS_CONFIGURED: prdata = {31'd0, cfg_q.is_configured};
      default:           prdata = 32'd0;
    endcase
  end

  assign accept = push && !full;

  ipv4c_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  ipv4c_rec_queue u_rec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (full),
    .valid_o (rec_valid),
    .pop_i   (rec_pop),
    .rec_o   (rec_head)
  );

  ipv4c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_head),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule
